/* sv/mrwt_pkg.sv */
package mrwt_pkg;

  localparam int NumberWidthDefault = 63;

  typedef struct packed {
    logic [62:0] number;
    logic [62:0] base;
  } mrwt_req_t;

  typedef struct packed {
    logic composite;
    logic trivially_decided;
  } mrwt_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_REDUCE,
    ST_POW_SEL,
    ST_MUL,
    ST_POW_NEXT,
    ST_SQ_CHECK,
    ST_DONE
  } mrwt_state_t;

  // which product the shared multiplier is computing
  typedef enum logic [1:0] {
    OP_ACC_TIMES_BASE,
    OP_BASE_SQUARE,
    OP_CUR_SQUARE
  } mrwt_op_t;

endpackage

/* sv/miller_rabin_witness_test_core.sv */
// Miller-Rabin witness test core. Each request carries a number n and one
// witness base a; one response says whether this base proves n composite.
// n < 2, n == 2 and even n are answered with trivially_decided set, the
// response being valid the cycle after the request is taken. Otherwise the
// core splits n-1 into x*2^t, reduces the base with a restoring divider
// (one quotient bit per cycle), then runs square-and-multiply and up to t
// squarings on one bit-serial multiply-mod unit that consumes one
// multiplier bit per cycle. Each modular product has its own setup and
// writeback states, so the cost is set by the bit length of x, its number
// of set bits and t. One request is processed at a time. The response
// sits in an output register, and a new request is taken once the
// response has been taken.
module miller_rabin_witness_test_core
  import mrwt_pkg::*;
#(
  parameter int NUMBER_WIDTH = NumberWidthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  mrwt_req_t in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output mrwt_rsp_t out_data
);

  localparam int W  = NUMBER_WIDTH;
  localparam int CW = $clog2(W + 1);

  mrwt_state_t state, state_next;

  logic [W-1:0]  n_reg;
  logic [W-1:0]  base_reg;   // running base / remainder
  logic [W-1:0]  exp_reg;    // exponent being consumed
  logic [W-1:0]  x_reg;      // odd part of n-1
  logic [W-1:0]  acc;        // power accumulator
  logic [W-1:0]  cur;
  logic [W-1:0]  lst;
  logic [W-1:0]  divq;       // dividend shift for reduction
  logic [5:0]    t_reg;
  logic [5:0]    sq_left;
  logic [CW-1:0] bit_cnt;
  logic          a_zero;

  // multiply-mod unit
  mrwt_op_t      op;
  logic [W-1:0]  mp;   // multiplicand
  logic [W-1:0]  mq;   // multiplier, shifted msb first
  logic [W-1:0]  mr;   // partial result
  logic [W:0]    dbl, dbl_red, addp;
  logic [W-1:0]  mr_step;

  logic          resp_valid;
  mrwt_rsp_t     resp;

  assign in_stall  = (state != ST_IDLE) || resp_valid;
  assign out_valid = resp_valid;
  assign out_data  = resp;

  // one multiplier bit per cycle: r = 2r (+p) mod n
  always_comb begin
    dbl     = {mr, 1'b0};
    dbl_red = (dbl >= {1'b0, n_reg}) ? dbl - {1'b0, n_reg} : dbl;
    addp    = dbl_red + {1'b0, mp};
    if (mq[W-1]) begin
      mr_step = (addp >= {1'b0, n_reg}) ? W'(addp - {1'b0, n_reg}) : addp[W-1:0];
    end else begin
      mr_step = dbl_red[W-1:0];
    end
  end

  // restoring reduction step
  logic [W:0] rem_sh;
  always_comb begin
    rem_sh = {base_reg, divq[W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      resp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (resp_valid && !out_stall) resp_valid <= 1'b0;
      if (state == ST_DONE) resp_valid <= 1'b1;
      if (state == ST_IDLE && in_valid && !resp_valid) begin
        if (in_data.number[W-1:0] < W'(3) || !in_data.number[0]) begin
          resp_valid <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !resp_valid) begin
          if (!(in_data.number[W-1:0] < W'(3) || !in_data.number[0]))
            state_next = ST_SPLIT;
        end
      end
      ST_SPLIT:    if (x_reg[0]) state_next = ST_REDUCE;
      ST_REDUCE:   if (bit_cnt == CW'(W)) state_next = ST_POW_SEL;
      ST_POW_SEL:  state_next = (exp_reg == '0) ? ST_SQ_CHECK : ST_MUL;
      ST_MUL:      if (bit_cnt == CW'(W)) state_next = ST_POW_NEXT;
      ST_POW_NEXT: begin
        if (op == OP_CUR_SQUARE) state_next = ST_SQ_CHECK;
        else if (op == OP_ACC_TIMES_BASE) state_next = ST_MUL;
        else state_next = ST_POW_SEL;
      end
      ST_SQ_CHECK: state_next = (sq_left == '0) ? ST_DONE : ST_MUL;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  logic comp;

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !resp_valid) begin
          n_reg    <= in_data.number[W-1:0];
          x_reg    <= in_data.number[W-1:0] - W'(1);
          divq     <= in_data.base[W-1:0];
          base_reg <= '0;
          t_reg    <= '0;
          bit_cnt  <= '0;
          comp     <= 1'b0;
          resp.composite         <= (in_data.number[W-1:0] != W'(2));
          resp.trivially_decided <= 1'b1;
        end
      end
      ST_SPLIT: begin
        if (!x_reg[0]) begin
          x_reg <= x_reg >> 1;
          t_reg <= t_reg + 6'd1;
        end
      end
      ST_REDUCE: begin
        if (bit_cnt != CW'(W)) begin
          base_reg <= (rem_sh >= {1'b0, n_reg}) ? W'(rem_sh - {1'b0, n_reg})
                                                : rem_sh[W-1:0];
          divq     <= divq << 1;
          bit_cnt  <= bit_cnt + CW'(1);
        end else begin
          a_zero  <= (base_reg == '0);
          exp_reg <= x_reg;
          acc     <= W'(1);
          sq_left <= t_reg;
        end
      end
      ST_POW_SEL: begin
        bit_cnt <= '0;
        mr      <= '0;
        if (exp_reg == '0) begin
          cur <= acc;
          lst <= acc;
        end else if (exp_reg[0]) begin
          op <= OP_ACC_TIMES_BASE; mp <= acc; mq <= base_reg;
        end else begin
          op <= OP_BASE_SQUARE; mp <= base_reg; mq <= base_reg;
        end
      end
      ST_MUL: begin
        if (bit_cnt != CW'(W)) begin
          mr      <= mr_step;
          mq      <= mq << 1;
          bit_cnt <= bit_cnt + CW'(1);
        end
      end
      ST_POW_NEXT: begin
        bit_cnt <= '0;
        unique case (op)
          OP_ACC_TIMES_BASE: begin
            acc <= mr; mr <= '0;
            op <= OP_BASE_SQUARE; mp <= base_reg; mq <= base_reg;
          end
          OP_BASE_SQUARE: begin
            base_reg <= mr; exp_reg <= exp_reg >> 1;
          end
          default: begin
            if (mr == W'(1) && lst != W'(1) && lst != n_reg - W'(1)) begin
              comp    <= 1'b1;
              sq_left <= '0;
            end else begin
              lst <= mr;
            end
            cur <= mr;
          end
        endcase
      end
      ST_SQ_CHECK: begin
        bit_cnt <= '0;
        mr      <= '0;
        if (sq_left != '0) begin
          op <= OP_CUR_SQUARE; mp <= cur; mq <= cur;
          sq_left <= sq_left - 6'd1;
        end
      end
      ST_DONE: begin
        resp.composite         <= !a_zero && (comp || cur != W'(1));
        resp.trivially_decided <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

/* sv/mrwt_checker.sv */
module mrwt_checker
  import mrwt_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input mrwt_req_t in_data,
  input logic      out_valid,
  input logic      out_stall,
  input mrwt_rsp_t out_data
);

  // a stalled response holds its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("response changed while stalled");

  // no request taken while a response is pending
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted with response pending");

  // two is reported prime by the trivial path
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.number == 63'd2 |=>
      out_valid && !out_data.composite && out_data.trivially_decided)
    else $error("two not reported prime");

  // even numbers other than two are composite immediately
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !in_data.number[0] && in_data.number != 63'd2 |=>
      out_valid && out_data.composite)
    else $error("even number not composite");

endmodule

bind miller_rabin_witness_test_core mrwt_checker u_mrwt_checker (.*);
